>>> src/btb_pkg.sv
// shared types and constants for the branch target buffer
package btb_pkg;

  // random replacement lfsr
  localparam int unsigned LFSR_W = 16;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 16'hACE1;
  localparam logic [LFSR_W-1:0] LFSR_MASK = 16'hB400;

  // operation codes
  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_SAVE   = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_FINISH
  } btb_state_t;

  // search word handed from stage to stage
  typedef struct packed {
    logic        op;
    logic [31:0] addr;
    logic [31:0] tgt;
    logic        found;
    logic        free_seen;
    logic [31:0] hit_target;
  } btb_tok_t;

  // write request broadcast to every stage
  typedef struct packed {
    logic        en;
    logic [31:0] addr;
    logic [31:0] tgt;
  } btb_wr_t;

endpackage

>>> src/btb_cell.sv
// one table entry with its compare stage in the search chain
module btb_cell #(
  parameter int unsigned IW  = 4,
  parameter int unsigned IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  btb_pkg::btb_tok_t tok_in,
  input  logic              tok_in_vld,
  input  logic [IW-1:0]     hit_idx_in,
  input  logic [IW-1:0]     free_idx_in,
  input  btb_pkg::btb_wr_t  wr,
  input  logic [IW-1:0]     wr_idx,
  output btb_pkg::btb_tok_t tok_out,
  output logic              tok_out_vld,
  output logic [IW-1:0]     hit_idx_out,
  output logic [IW-1:0]     free_idx_out
);

  localparam logic [IW-1:0] MY_IDX = IW'(IDX);

  logic              valid_r;
  logic [31:0]       branch_r;
  logic [31:0]       target_r;
  btb_pkg::btb_tok_t tok_r;
  btb_pkg::btb_tok_t tok_nxt;
  logic              tok_vld_r;
  logic [IW-1:0]     hit_idx_r;
  logic [IW-1:0]     hit_idx_nxt;
  logic [IW-1:0]     free_idx_r;
  logic [IW-1:0]     free_idx_nxt;
  logic              match;
  logic              wr_here;

  assign match   = valid_r && (branch_r == tok_in.addr);
  assign wr_here = wr.en && (wr_idx == MY_IDX);

  // first match and first free entry win
  always_comb begin
    tok_nxt      = tok_in;
    hit_idx_nxt  = hit_idx_in;
    free_idx_nxt = free_idx_in;
    if (!tok_in.found && match) begin
      tok_nxt.found      = 1'b1;
      tok_nxt.hit_target = target_r;
      hit_idx_nxt        = MY_IDX;
    end
    if (!tok_in.free_seen && !valid_r) begin
      tok_nxt.free_seen = 1'b1;
      free_idx_nxt      = MY_IDX;
    end
  end

  // control: entry valid and word valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_vld_r <= 1'b0;
    end else begin
      tok_vld_r <= tok_in_vld;
      if (wr_here) begin
        valid_r <= 1'b1;
      end
    end
  end

  // payload: entry contents and search word
  always_ff @(posedge clk) begin
    if (wr_here) begin
      branch_r <= wr.addr;
      target_r <= wr.tgt;
    end
    if (tok_in_vld) begin
      tok_r      <= tok_nxt;
      hit_idx_r  <= hit_idx_nxt;
      free_idx_r <= free_idx_nxt;
    end
  end

  assign tok_out      = tok_r;
  assign tok_out_vld  = tok_vld_r;
  assign hit_idx_out  = hit_idx_r;
  assign free_idx_out = free_idx_r;

endmodule

>>> src/btb_lfsr.sv
// replacement lfsr and its value modulo the entry count
module btb_lfsr #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  output logic [$clog2(ENTRIES)-1:0] victim,
  output logic                       ready
);

  localparam int unsigned IW = $clog2(ENTRIES);
  localparam int unsigned LW = btb_pkg::LFSR_W;
  localparam int unsigned RW = LW + 1;
  localparam int unsigned PW = LW + RW;
  localparam int unsigned SH = LW + IW;
  // rounded-up reciprocal, gives the exact quotient for every lfsr value
  localparam logic [RW-1:0] RECIP =
    RW'(((64'd1 << SH) + 64'(ENTRIES - 1)) / 64'(ENTRIES));
  localparam logic [LW-1:0] N = LW'(ENTRIES);

  logic [LW-1:0] lfsr_r;
  logic [LW-1:0] lfsr_nxt;
  logic [PW-1:0] prod;
  logic [LW-1:0] quo_r;
  logic [LW-1:0] quo_nxt;
  logic [LW-1:0] back;
  logic [IW-1:0] rem_r;
  logic [IW-1:0] rem_nxt;
  logic          quo_ok_r;
  logic          rem_ok_r;

  // galois step, only on a replacement
  assign lfsr_nxt = step ? ((lfsr_r >> 1) ^ (lfsr_r[0] ? btb_pkg::LFSR_MASK : '0)) : lfsr_r;

  // quotient by reciprocal multiply, remainder from the registered quotient
  assign prod    = PW'(lfsr_r) * PW'(RECIP);
  assign quo_nxt = LW'(prod >> SH);
  assign back    = quo_r * N;
  assign rem_nxt = IW'(lfsr_r - back);

  // lfsr and the flags that track which stage matches it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r   <= btb_pkg::LFSR_SEED;
      quo_ok_r <= 1'b0;
      rem_ok_r <= 1'b0;
    end else begin
      lfsr_r   <= lfsr_nxt;
      quo_ok_r <= !step;
      rem_ok_r <= !step && quo_ok_r;
    end
  end

  // quotient and remainder registers
  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign ready  = rem_ok_r;
  assign victim = rem_r;

endmodule

>>> src/branch_target_buffer_core.sv
// fully associative branch target buffer built as a row of entry stages
//
//  channel  direction  handshake            payload
//  in_      slave      in_tvalid/in_tready  tdata: branch_addr, new_target; tuser: op
//  out_     master     out_tvalid/out_tready tdata: target_out, slot; tuser: hit, evicted
//
// the search word walks the stage row one entry per cycle, then the finish
// state writes the result and, on a save that missed, the table.
// the replacement victim is ready once the quotient and remainder registers have
// caught up after the previous replacement or after reset, so it never holds up an item.
// reset clears all entry valid bits at once; there is no clearing pass.
// the result sits in an output register; the next item is taken while it
// waits, and finishing stalls only while that register is still full.
module branch_target_buffer_core #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] branch_addr, [63:32] new_target
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] target_out, [35:32] slot, [39:36] zero
  output logic [1:0]  out_tuser   // [0] hit, [1] evicted
);

  localparam int unsigned IW = $clog2(ENTRIES);

  btb_pkg::btb_state_t state_r;
  btb_pkg::btb_state_t state_nxt;

  btb_pkg::btb_tok_t tok   [ENTRIES+1];
  logic              vld   [ENTRIES+1];
  logic [IW-1:0]     hidx  [ENTRIES+1];
  logic [IW-1:0]     fidx  [ENTRIES+1];

  btb_pkg::btb_tok_t last;
  btb_pkg::btb_wr_t  wr;
  logic [IW-1:0]     wr_idx;
  logic [IW-1:0]     victim;
  logic              victim_ok;
  logic              in_acc;
  logic              need_evict;
  logic              commit;
  logic              lfsr_step;

  logic              out_valid_r;
  logic              out_hit_r;
  logic              out_evict_r;
  logic [31:0]       out_target_r;
  logic [3:0]        out_slot_r;
  logic [31:0]       target_nxt;
  logic [3:0]        slot_nxt;

  assign in_acc = in_tvalid && in_tready;

  // search word entering the first stage
  always_comb begin
    tok[0]            = '0;
    tok[0].op         = in_tuser[0];
    tok[0].addr       = in_tdata[31:0];
    tok[0].tgt        = in_tdata[63:32];
    vld[0]            = in_acc;
    hidx[0]           = '0;
    fidx[0]           = '0;
  end

  // row of entry stages
  for (genvar i = 0; i < ENTRIES; i++) begin : g_row
    btb_cell #(
      .IW  (IW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .tok_in       (tok[i]),
      .tok_in_vld   (vld[i]),
      .hit_idx_in   (hidx[i]),
      .free_idx_in  (fidx[i]),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .tok_out      (tok[i+1]),
      .tok_out_vld  (vld[i+1]),
      .hit_idx_out  (hidx[i+1]),
      .free_idx_out (fidx[i+1])
    );
  end

  assign last = tok[ENTRIES];

  btb_lfsr #(
    .ENTRIES (ENTRIES)
  ) u_lfsr (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (lfsr_step),
    .victim (victim),
    .ready  (victim_ok)
  );

  // decision at the end of the row
  assign need_evict = !last.found && (last.op == btb_pkg::OP_SAVE) && !last.free_seen;
  assign wr_idx     = last.free_seen ? fidx[ENTRIES] : victim;

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    commit    = 1'b0;
    unique case (state_r)
      btb_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = btb_pkg::ST_SEARCH;
        end
      end
      btb_pkg::ST_SEARCH: begin
        if (vld[ENTRIES]) begin
          state_nxt = btb_pkg::ST_FINISH;
        end
      end
      btb_pkg::ST_FINISH: begin
        if ((!out_valid_r || out_tready) && (!need_evict || victim_ok)) begin
          commit    = 1'b1;
          state_nxt = btb_pkg::ST_IDLE;
        end
      end
      default: state_nxt = btb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= btb_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // table write on a save that missed
  assign wr.en     = commit && !last.found && (last.op == btb_pkg::OP_SAVE);
  assign wr.addr   = last.addr;
  assign wr.tgt    = last.tgt;
  assign lfsr_step = commit && need_evict;

  // result fields
  always_comb begin
    priority if (last.found) begin
      target_nxt = last.hit_target;
      slot_nxt   = 4'(hidx[ENTRIES]);
    end else if (last.op == btb_pkg::OP_LOOKUP) begin
      target_nxt = last.addr;
      slot_nxt   = '0;
    end else begin
      target_nxt = '0;
      slot_nxt   = 4'(wr_idx);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_hit_r    <= last.found;
      out_evict_r  <= need_evict;
      out_target_r <= target_nxt;
      out_slot_r   <= slot_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_slot_r, out_target_r};
  assign out_tuser  = {out_evict_r, out_hit_r};

  // checks
  a_accept_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == btb_pkg::ST_SEARCH))
    else $error("accepted word did not start a search");

  a_row_end_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    vld[ENTRIES] |-> (state_r == btb_pkg::ST_SEARCH))
    else $error("search word left the row outside a search");

  a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == btb_pkg::ST_FINISH))
    else $error("result appeared without a finished search");

  a_evict_needs_victim: assert property (@(posedge clk) disable iff (!rst_n)
    lfsr_step |-> victim_ok && wr.en)
    else $error("replacement without a ready victim");

endmodule
